// ----- design/dllm_pkg.sv -----
// Shared types and constants for the circular doubly linked list manager.
// Holds the request and result structs, action codes, sequencer states and
// the link store's access structs. Depends on nothing.
`default_nettype none

package dllm_pkg;

  // NODES must be a power of two so that a node number wraps by truncation.
  localparam int NODES  = 256;
  localparam int NODE_W = $clog2(NODES);

  typedef logic [NODE_W-1:0] node_t;

  typedef enum logic [3:0] {
    ACT_INIT     = 4'd0,
    ACT_ADD      = 4'd1,
    ACT_ADD_TAIL = 4'd2,
    ACT_DEL      = 4'd3,
    ACT_REPLACE  = 4'd4,
    ACT_SWAP     = 4'd5,
    ACT_MOVE     = 4'd6,
    ACT_MOVE_TAIL = 4'd7,
    ACT_IS_FIRST = 4'd8,
    ACT_IS_LAST  = 4'd9,
    ACT_IS_HEAD  = 4'd10,
    ACT_IS_EMPTY = 4'd11
  } action_t;

  typedef struct packed {
    logic [3:0] action;
    logic [7:0] node_a;
    logic [7:0] node_b;
  } in_req_t;

  typedef struct packed {
    logic       answer;
    logic [7:0] next_of_a;
    logic [7:0] prev_of_a;
    logic       a_linked;
  } out_res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_BR_RD,
    S_BR_WR,
    S_CLR,
    S_TP_RD1,
    S_TP_WR1,
    S_TP_RD2,
    S_TP_WR2,
    S_SP_RD,
    S_SP_WR1,
    S_SP_WR2,
    S_Q_RD,
    S_FIN_RD,
    S_DONE
  } state_t;

  // One access slot on the link store: a read of each link memory, a write
  // to each link memory, one update of the linked marks and one read of them.
  typedef struct packed {
    node_t next_ra;
    node_t prev_ra;
    logic  next_we;
    node_t next_wa;
    node_t next_wd;
    logic  prev_we;
    node_t prev_wa;
    node_t prev_wd;
    logic  mark_we;
    node_t mark_wa;
    logic  mark_wd;
    node_t mark_ra;
  } store_req_t;

  typedef struct packed {
    node_t next_q;
    node_t prev_q;
    logic  mark_q;
  } store_rsp_t;

  function automatic node_t node_of(input logic [7:0] v);
    return NODE_W'(v);
  endfunction

endpackage

`default_nettype wire

// ----- design/dllm_store.sv -----
// Link store: next and previous link memories and the per-node linked marks,
// all read through a register; reset clears the marks.
// Depends on dllm_pkg.
`default_nettype none

module dllm_store (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dllm_pkg::store_req_t req,
  output dllm_pkg::store_rsp_t     rsp
);

  dllm_pkg::node_t next_mem [dllm_pkg::NODES];
  dllm_pkg::node_t prev_mem [dllm_pkg::NODES];

  dllm_pkg::node_t             next_q_r;
  dllm_pkg::node_t             prev_q_r;
  logic [dllm_pkg::NODES-1:0]  mark_r;
  logic                        mark_q_r;

  always_ff @(posedge clk) begin
    if (req.next_we) begin
      next_mem[req.next_wa] <= req.next_wd;
    end
    next_q_r <= next_mem[req.next_ra];
  end

  always_ff @(posedge clk) begin
    if (req.prev_we) begin
      prev_mem[req.prev_wa] <= req.prev_wd;
    end
    prev_q_r <= prev_mem[req.prev_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= '0;
    end else if (req.mark_we) begin
      mark_r[req.mark_wa] <= req.mark_wd;
    end
    mark_q_r <= mark_r[req.mark_ra];
  end

  assign rsp.next_q = next_q_r;
  assign rsp.prev_q = prev_q_r;
  assign rsp.mark_q = mark_q_r;

endmodule

`default_nettype wire

// ----- design/doubly_linked_list_manager.sv -----
// Circular doubly linked list manager: top level with the request sequencer.
// Depends on dllm_pkg and dllm_store.
//
// A request is taken when start is high and busy is low; exactly one result
// follows, shown for one cycle with out_valid, and the receiver cannot stall
// it. busy drops while the result is shown, so the next request can be taken
// at the same edge as the result. The link memories set the pace of a
// request: each has one read and one write port with a registered read, so
// every dependent link read is a step of its own and the writes of a step
// are issued in the order the list operation defines.
`default_nettype none

module doubly_linked_list_manager (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire dllm_pkg::in_req_t in_req,
  output logic                   out_valid,
  output dllm_pkg::out_res_t     out_res
);

  dllm_pkg::state_t     state_r, state_nxt;
  dllm_pkg::action_t    act_r;
  dllm_pkg::node_t      a_r, b_r, e_r, h_r, pos_r, p_r;
  logic                 empty_r;
  logic                 out_valid_r;
  dllm_pkg::out_res_t   out_res_r;
  logic                 after_head;
  logic                 answer;
  dllm_pkg::node_t      sp_next, sp_prev;

  dllm_pkg::store_req_t sreq;
  dllm_pkg::store_rsp_t srsp;

  dllm_store u_store (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (sreq),
    .rsp   (srsp)
  );

  // Insertion after the head for add, move and the last step of swap.
  assign after_head = (act_r inside {dllm_pkg::ACT_ADD, dllm_pkg::ACT_MOVE,
                                     dllm_pkg::ACT_SWAP});
  assign sp_next    = after_head ? srsp.next_q : h_r;
  assign sp_prev    = after_head ? h_r : srsp.prev_q;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dllm_pkg::S_IDLE: begin
        if (start) begin
          case (dllm_pkg::action_t'(in_req.action))
            dllm_pkg::ACT_INIT:      state_nxt = dllm_pkg::S_INIT;
            dllm_pkg::ACT_ADD,
            dllm_pkg::ACT_ADD_TAIL:  state_nxt = dllm_pkg::S_SP_RD;
            dllm_pkg::ACT_DEL,
            dllm_pkg::ACT_SWAP,
            dllm_pkg::ACT_MOVE,
            dllm_pkg::ACT_MOVE_TAIL: state_nxt = dllm_pkg::S_BR_RD;
            dllm_pkg::ACT_REPLACE:   state_nxt = dllm_pkg::S_TP_RD1;
            dllm_pkg::ACT_IS_EMPTY:  state_nxt = dllm_pkg::S_Q_RD;
            default:                 state_nxt = dllm_pkg::S_FIN_RD;
          endcase
        end
      end
      dllm_pkg::S_INIT:   state_nxt = dllm_pkg::S_FIN_RD;
      dllm_pkg::S_BR_RD:  state_nxt = dllm_pkg::S_BR_WR;
      dllm_pkg::S_BR_WR: begin
        if (act_r inside {dllm_pkg::ACT_DEL, dllm_pkg::ACT_SWAP}) begin
          state_nxt = dllm_pkg::S_CLR;
        end else begin
          state_nxt = dllm_pkg::S_SP_RD;
        end
      end
      dllm_pkg::S_CLR: begin
        if (act_r == dllm_pkg::ACT_SWAP) begin
          state_nxt = dllm_pkg::S_TP_RD1;
        end else begin
          state_nxt = dllm_pkg::S_FIN_RD;
        end
      end
      dllm_pkg::S_TP_RD1: state_nxt = dllm_pkg::S_TP_WR1;
      dllm_pkg::S_TP_WR1: state_nxt = dllm_pkg::S_TP_RD2;
      dllm_pkg::S_TP_RD2: state_nxt = dllm_pkg::S_TP_WR2;
      dllm_pkg::S_TP_WR2: begin
        if (act_r == dllm_pkg::ACT_SWAP) begin
          state_nxt = dllm_pkg::S_SP_RD;
        end else begin
          state_nxt = dllm_pkg::S_FIN_RD;
        end
      end
      dllm_pkg::S_SP_RD:  state_nxt = dllm_pkg::S_SP_WR1;
      dllm_pkg::S_SP_WR1: state_nxt = dllm_pkg::S_SP_WR2;
      dllm_pkg::S_SP_WR2: state_nxt = dllm_pkg::S_FIN_RD;
      dllm_pkg::S_Q_RD:   state_nxt = dllm_pkg::S_FIN_RD;
      dllm_pkg::S_FIN_RD: state_nxt = dllm_pkg::S_DONE;
      dllm_pkg::S_DONE:   state_nxt = dllm_pkg::S_IDLE;
      default:            state_nxt = dllm_pkg::S_IDLE;
    endcase
  end

  // Store accesses for each step. Reads land in srsp in the next cycle.
  always_comb begin
    sreq         = '0;
    sreq.next_ra = a_r;
    sreq.prev_ra = a_r;
    sreq.mark_ra = a_r;
    case (state_r)
      dllm_pkg::S_INIT: begin
        sreq.next_we = 1'b1;
        sreq.next_wa = a_r;
        sreq.next_wd = a_r;
        sreq.prev_we = 1'b1;
        sreq.prev_wa = a_r;
        sreq.prev_wd = a_r;
        sreq.mark_we = 1'b1;
        sreq.mark_wa = a_r;
        sreq.mark_wd = 1'b1;
      end
      dllm_pkg::S_BR_RD: begin
        sreq.next_ra = e_r;
        sreq.prev_ra = e_r;
      end
      dllm_pkg::S_BR_WR: begin
        // Neighbors of the removed node now point at each other.
        sreq.prev_we = 1'b1;
        sreq.prev_wa = srsp.next_q;
        sreq.prev_wd = srsp.prev_q;
        sreq.next_we = 1'b1;
        sreq.next_wa = srsp.prev_q;
        sreq.next_wd = srsp.next_q;
      end
      dllm_pkg::S_CLR: begin
        sreq.next_we = 1'b1;
        sreq.next_wa = e_r;
        sreq.next_wd = '0;
        sreq.prev_we = 1'b1;
        sreq.prev_wa = e_r;
        sreq.prev_wd = '0;
        sreq.mark_we = 1'b1;
        sreq.mark_wa = e_r;
        sreq.mark_wd = 1'b0;
      end
      dllm_pkg::S_TP_RD1: begin
        sreq.next_ra = a_r;
      end
      dllm_pkg::S_TP_WR1: begin
        sreq.next_we = 1'b1;
        sreq.next_wa = b_r;
        sreq.next_wd = srsp.next_q;
        sreq.prev_we = 1'b1;
        sreq.prev_wa = srsp.next_q;
        sreq.prev_wd = b_r;
      end
      dllm_pkg::S_TP_RD2: begin
        // Issued after the first half so an aliased old node reads fresh.
        sreq.prev_ra = a_r;
      end
      dllm_pkg::S_TP_WR2: begin
        sreq.prev_we = 1'b1;
        sreq.prev_wa = b_r;
        sreq.prev_wd = srsp.prev_q;
        sreq.next_we = 1'b1;
        sreq.next_wa = srsp.prev_q;
        sreq.next_wd = b_r;
        sreq.mark_we = 1'b1;
        sreq.mark_wa = b_r;
        sreq.mark_wd = 1'b1;
      end
      dllm_pkg::S_SP_RD: begin
        sreq.next_ra = h_r;
        sreq.prev_ra = h_r;
      end
      dllm_pkg::S_SP_WR1: begin
        sreq.prev_we = 1'b1;
        sreq.prev_wa = sp_next;
        sreq.prev_wd = a_r;
        sreq.next_we = 1'b1;
        sreq.next_wa = a_r;
        sreq.next_wd = sp_next;
      end
      dllm_pkg::S_SP_WR2: begin
        sreq.prev_we = 1'b1;
        sreq.prev_wa = a_r;
        sreq.prev_wd = p_r;
        sreq.next_we = 1'b1;
        sreq.next_wa = p_r;
        sreq.next_wd = a_r;
        sreq.mark_we = 1'b1;
        sreq.mark_wa = a_r;
        sreq.mark_wd = 1'b1;
      end
      dllm_pkg::S_Q_RD: begin
        sreq.next_ra = b_r;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (act_r)
      dllm_pkg::ACT_IS_FIRST: answer = (srsp.prev_q == b_r);
      dllm_pkg::ACT_IS_LAST:  answer = (srsp.next_q == b_r);
      dllm_pkg::ACT_IS_HEAD:  answer = (a_r == b_r);
      dllm_pkg::ACT_IS_EMPTY: answer = empty_r;
      default:                answer = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dllm_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == dllm_pkg::S_DONE);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      dllm_pkg::S_IDLE: begin
        if (start) begin
          act_r <= dllm_pkg::action_t'(in_req.action);
          a_r   <= dllm_pkg::node_of(in_req.node_a);
          b_r   <= dllm_pkg::node_of(in_req.node_b);
          h_r   <= dllm_pkg::node_of(in_req.node_b);
          if (dllm_pkg::action_t'(in_req.action) == dllm_pkg::ACT_SWAP) begin
            e_r <= dllm_pkg::node_of(in_req.node_b);
          end else begin
            e_r <= dllm_pkg::node_of(in_req.node_a);
          end
        end
      end
      dllm_pkg::S_BR_WR: begin
        pos_r <= srsp.prev_q;
      end
      dllm_pkg::S_TP_WR2: begin
        // Swap reinserts A where B was; if that spot was A itself, use B.
        h_r <= (pos_r == a_r) ? b_r : pos_r;
      end
      dllm_pkg::S_SP_WR1: begin
        p_r <= sp_prev;
      end
      dllm_pkg::S_FIN_RD: begin
        empty_r <= (srsp.next_q == b_r);
      end
      dllm_pkg::S_DONE: begin
        out_res_r.answer    <= answer;
        out_res_r.next_of_a <= 8'(srsp.next_q);
        out_res_r.prev_of_a <= 8'(srsp.prev_q);
        out_res_r.a_linked  <= srsp.mark_q;
      end
      default: begin
      end
    endcase
  end

  assign busy      = (state_r != dllm_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

`default_nettype wire

// ----- design/dllm_checker.sv -----
// Port-level checker for the list manager and its bind to the top level.
// Depends on doubly_linked_list_manager.
`default_nettype none

module dllm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid
);

  // An accepted request keeps the block busy in the following cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // A result never appears while a request is still being worked on.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // Every result ends a busy period.
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a preceding request");

  // Finishing a request always delivers its result.
  a_busy_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("request finished without a result");

  // One request gives exactly one result strobe.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

endmodule

bind doubly_linked_list_manager dllm_checker u_dllm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

`default_nettype wire

// ----- bench/dllm_list_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the circular doubly linked list manager: keeps its own
// copy of the link store, predicts each result and compares it with the block.
// Depends on dllm_pkg.

module dllm_list_checker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              busy,
  input  wire dllm_pkg::in_req_t in_req,
  input  wire logic              out_valid,
  input  wire dllm_pkg::out_res_t out_res,
  output int                     failures,
  output int                     pending,
  output int                     checked,
  output int                     true_answers
);

  typedef struct {
    dllm_pkg::in_req_t  req;
    dllm_pkg::out_res_t res;
  } awaited_t;

  dllm_pkg::node_t succ [dllm_pkg::NODES];
  dllm_pkg::node_t pred [dllm_pkg::NODES];
  bit              on_list [dllm_pkg::NODES];
  awaited_t        awaited_results [$];

  function automatic void splice(dllm_pkg::node_t n, dllm_pkg::node_t p,
                                 dllm_pkg::node_t x);
    pred[x] = n;
    succ[n] = x;
    pred[n] = p;
    succ[p] = n;
    on_list[n] = 1'b1;
  endfunction

  function automatic void join_ends(dllm_pkg::node_t p, dllm_pkg::node_t x);
    pred[x] = p;
    succ[p] = x;
  endfunction

  function automatic void unlink(dllm_pkg::node_t e);
    join_ends(pred[e], succ[e]);
    succ[e] = '0;
    pred[e] = '0;
    on_list[e] = 1'b0;
  endfunction

  function automatic void stand_in(dllm_pkg::node_t o, dllm_pkg::node_t n);
    succ[n] = succ[o];
    pred[succ[n]] = n;
    pred[n] = pred[o];
    succ[pred[n]] = n;
    on_list[n] = 1'b1;
  endfunction

  // Applies one request to the shadow lists and returns node A's view after it.
  function automatic dllm_pkg::out_res_t apply_list_request(dllm_pkg::in_req_t r);
    dllm_pkg::node_t    a;
    dllm_pkg::node_t    b;
    dllm_pkg::node_t    pos;
    logic               ans;
    dllm_pkg::out_res_t res;
    a = dllm_pkg::node_t'(int'(r.node_a) % dllm_pkg::NODES);
    b = dllm_pkg::node_t'(int'(r.node_b) % dllm_pkg::NODES);
    ans = 1'b0;
    case (r.action)
      dllm_pkg::ACT_INIT: begin
        succ[a] = a;
        pred[a] = a;
        on_list[a] = 1'b1;
      end
      dllm_pkg::ACT_ADD:      splice(a, b, succ[b]);
      dllm_pkg::ACT_ADD_TAIL: splice(a, pred[b], b);
      dllm_pkg::ACT_DEL:      unlink(a);
      dllm_pkg::ACT_REPLACE:  stand_in(a, b);
      dllm_pkg::ACT_SWAP: begin
        // When B directly follows A, A goes back after B's new position.
        pos = pred[b];
        unlink(b);
        stand_in(a, b);
        if (pos == a) pos = b;
        splice(a, pos, succ[pos]);
      end
      dllm_pkg::ACT_MOVE: begin
        join_ends(pred[a], succ[a]);
        splice(a, b, succ[b]);
      end
      dllm_pkg::ACT_MOVE_TAIL: begin
        join_ends(pred[a], succ[a]);
        splice(a, pred[b], b);
      end
      dllm_pkg::ACT_IS_FIRST: ans = (pred[a] == b);
      dllm_pkg::ACT_IS_LAST:  ans = (succ[a] == b);
      dllm_pkg::ACT_IS_HEAD:  ans = (a == b);
      dllm_pkg::ACT_IS_EMPTY: ans = (succ[b] == b);
      default: ;
    endcase
    res.answer    = ans;
    res.next_of_a = 8'(succ[a]);
    res.prev_of_a = 8'(pred[a]);
    res.a_linked  = on_list[a];
    return res;
  endfunction

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got,
                                      dllm_pkg::in_req_t req);
    if (got !== want) begin
      failures++;
      $display("%0t: action %0d A %0d B %0d: %s expected %0d, got %0d",
               $time, req.action, req.node_a, req.node_b, field, want, got);
    end
  endfunction

  always @(posedge clk) begin : watch
    awaited_t head;
    if (!rst_n) begin
      for (int i = 0; i < dllm_pkg::NODES; i++) begin
        succ[i] = '0;
        pred[i] = '0;
        on_list[i] = 1'b0;
      end
      awaited_results.delete();
      failures = 0;
      checked = 0;
      true_answers = 0;
    end else begin
      // A result always belongs to an earlier request, so it is matched first.
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          failures++;
          $display("%0t: result with nothing expected: answer %0d next %0d prev %0d linked %0d",
                   $time, out_res.answer, out_res.next_of_a, out_res.prev_of_a,
                   out_res.a_linked);
        end else begin
          head = awaited_results.pop_front();
          check_field("answer", 8'(head.res.answer), 8'(out_res.answer), head.req);
          check_field("next_of_a", head.res.next_of_a, out_res.next_of_a, head.req);
          check_field("prev_of_a", head.res.prev_of_a, out_res.prev_of_a, head.req);
          check_field("a_linked", 8'(head.res.a_linked), 8'(out_res.a_linked), head.req);
          checked++;
          if (out_res.answer === 1'b1) true_answers++;
        end
      end
      if (start && !busy) begin
        head.req = in_req;
        head.res = apply_list_request(in_req);
        awaited_results.push_back(head);
      end
    end
    pending = awaited_results.size();
  end

endmodule

// ----- bench/tb_doubly_linked_list_manager.sv -----
`timescale 1ns / 1ps
// Testbench top for the circular doubly linked list manager: clock, reset,
// request stimulus and the verdict. Depends on dllm_pkg, the block itself
// and dllm_list_checker.

module tb_doubly_linked_list_manager;

  localparam int         RANDOM_REQUESTS = 525;
  localparam int         CYCLE_LIMIT     = 200000;
  localparam int         DRAIN_CYCLES    = 24;
  localparam logic [3:0] RESERVED_ACT_LO = 4'd12;
  localparam logic [3:0] RESERVED_ACT_HI = 4'd15;

  logic               clk    = 1'b0;
  logic               rst_n  = 1'b0;
  logic               start  = 1'b0;
  dllm_pkg::in_req_t  in_req = '0;
  logic               busy;
  logic               out_valid;
  dllm_pkg::out_res_t out_res;

  int fail_count;
  int pending_count;
  int checked_count;
  int true_count;
  int sent_count = 0;
  int cycle_count = 0;
  bit bursty = 1'b1;

  // Nodes whose links have been written; only these may have their links read.
  bit         linked_once [dllm_pkg::NODES];
  logic [7:0] written_nodes [$];

  doubly_linked_list_manager dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  dllm_list_checker list_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_req       (in_req),
    .out_valid    (out_valid),
    .out_res      (out_res),
    .failures     (fail_count),
    .pending      (pending_count),
    .checked      (checked_count),
    .true_answers (true_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic void mark_written(logic [7:0] v);
    int n;
    n = int'(v) % dllm_pkg::NODES;
    if (!linked_once[n]) begin
      linked_once[n] = 1'b1;
      written_nodes.push_back(8'(n));
    end
  endfunction

  function automatic logic [7:0] any_node();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return 8'($urandom_range(0, 15));
    if (roll == 7) return 8'($urandom_range(240, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] written_node();
    return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
  endfunction

  // Operands whose links get read are drawn from nodes already written.
  // Every result shows node A's links, so A is written or written by the step.
  function automatic dllm_pkg::in_req_t random_request();
    dllm_pkg::in_req_t r;
    int                roll;
    roll = $urandom_range(0, 99);
    r.node_a = any_node();
    r.node_b = any_node();
    if (roll < 8) begin
      r.action = dllm_pkg::ACT_INIT;
    end else if (roll < 22) begin
      r.action = dllm_pkg::ACT_ADD;
      r.node_b = written_node();
    end else if (roll < 36) begin
      r.action = dllm_pkg::ACT_ADD_TAIL;
      r.node_b = written_node();
    end else if (roll < 44) begin
      r.action = dllm_pkg::ACT_DEL;
      r.node_a = written_node();
    end else if (roll < 51) begin
      r.action = dllm_pkg::ACT_REPLACE;
      r.node_a = written_node();
    end else if (roll < 60) begin
      r.action = dllm_pkg::ACT_SWAP;
      r.node_a = written_node();
      r.node_b = written_node();
    end else if (roll < 69) begin
      r.action = dllm_pkg::ACT_MOVE;
      r.node_a = written_node();
      r.node_b = written_node();
    end else if (roll < 78) begin
      r.action = dllm_pkg::ACT_MOVE_TAIL;
      r.node_a = written_node();
      r.node_b = written_node();
    end else if (roll < 83) begin
      r.action = dllm_pkg::ACT_IS_FIRST;
      r.node_a = written_node();
    end else if (roll < 88) begin
      r.action = dllm_pkg::ACT_IS_LAST;
      r.node_a = written_node();
    end else if (roll < 92) begin
      r.action = dllm_pkg::ACT_IS_HEAD;
      r.node_a = written_node();
      if ($urandom_range(0, 1)) r.node_b = r.node_a;
    end else if (roll < 97) begin
      r.action = dllm_pkg::ACT_IS_EMPTY;
      r.node_a = written_node();
      r.node_b = written_node();
    end else begin
      r.action = 4'($urandom_range(RESERVED_ACT_LO, RESERVED_ACT_HI));
      r.node_a = written_node();
    end
    return r;
  endfunction

  // Drives one request from a falling edge and returns once it is accepted.
  task automatic send_request(logic [3:0] act, logic [7:0] a, logic [7:0] b);
    int gap;
    gap = bursty ? $urandom_range(0, 14) : 0;
    @(negedge clk);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= '{action: act, node_a: a, node_b: b};
    @(posedge clk);
    while (busy) @(posedge clk);
    case (act)
      dllm_pkg::ACT_INIT, dllm_pkg::ACT_ADD, dllm_pkg::ACT_ADD_TAIL: mark_written(a);
      dllm_pkg::ACT_REPLACE:                                         mark_written(b);
      default: ;
    endcase
    sent_count++;
    if ($urandom_range(0, 39) == 0) bursty = !bursty;
  endtask

  initial begin
    dllm_pkg::in_req_t r;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Short lists around node 0, the highest node, aliasing and deleted nodes.
    send_request(dllm_pkg::ACT_INIT, 8'd0, 8'd0);
    send_request(dllm_pkg::ACT_INIT, 8'd255, 8'd255);
    send_request(dllm_pkg::ACT_IS_EMPTY, 8'd0, 8'd0);
    send_request(dllm_pkg::ACT_ADD, 8'd1, 8'd0);
    send_request(dllm_pkg::ACT_ADD_TAIL, 8'd2, 8'd0);
    send_request(dllm_pkg::ACT_ADD, 8'd255, 8'd1);
    send_request(dllm_pkg::ACT_IS_FIRST, 8'd1, 8'd0);
    send_request(dllm_pkg::ACT_IS_LAST, 8'd2, 8'd0);
    send_request(dllm_pkg::ACT_IS_HEAD, 8'd0, 8'd0);
    send_request(dllm_pkg::ACT_IS_HEAD, 8'd1, 8'd0);
    send_request(dllm_pkg::ACT_SWAP, 8'd1, 8'd2);
    send_request(dllm_pkg::ACT_SWAP, 8'd255, 8'd255);
    send_request(dllm_pkg::ACT_SWAP, 8'd2, 8'd0);
    send_request(dllm_pkg::ACT_MOVE, 8'd2, 8'd0);
    send_request(dllm_pkg::ACT_MOVE_TAIL, 8'd1, 8'd0);
    send_request(dllm_pkg::ACT_MOVE, 8'd1, 8'd1);
    send_request(dllm_pkg::ACT_REPLACE, 8'd255, 8'd128);
    send_request(dllm_pkg::ACT_DEL, 8'd1, 8'd0);
    send_request(dllm_pkg::ACT_IS_FIRST, 8'd1, 8'd0);
    send_request(dllm_pkg::ACT_MOVE, 8'd1, 8'd0);
    send_request(dllm_pkg::ACT_DEL, 8'd0, 8'd0);
    send_request(RESERVED_ACT_LO, 8'd2, 8'h55);
    send_request(RESERVED_ACT_HI, 8'd255, 8'hAA);
    send_request(dllm_pkg::ACT_IS_EMPTY, 8'd0, 8'd128);
    send_request(dllm_pkg::ACT_ADD_TAIL, 8'd3, 8'd128);

    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      // Halfway through, hold off until the block has answered everything.
      if (i == RANDOM_REQUESTS / 2) begin
        @(negedge clk);
        start <= 1'b0;
        while (pending_count != 0) @(negedge clk);
      end
      r = random_request();
      send_request(r.action, r.node_a, r.node_b);
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests (25 directed), %0d results checked, %0d queries true.",
             sent_count, checked_count, true_count);
    $display("%0d distinct nodes were linked; one full drain was forced mid-run.",
             written_nodes.size());
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
